FILE: hw/rtl/nlri_prefix_label_parser_core_assert.svh
// ----------------------------------------------------------------------------
// NLRI parser assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef NLRI_PREFIX_LABEL_PARSER_CORE_ASSERT_SVH
`define NLRI_PREFIX_LABEL_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define NLPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NLPP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/nlpp_pkg.sv
// ----------------------------------------------------------------------------
// NLRI parser package
// Shared types, phase codes and constants of the NLRI prefix/label parser.
// ----------------------------------------------------------------------------
package nlpp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_AFI_IPV6      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LABELED_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WITHDRAW_MODE = 2'd2;

    localparam logic [1:0] PH_LENGTH = 2'd0;
    localparam logic [1:0] PH_LABEL  = 2'd1;
    localparam logic [1:0] PH_PREFIX = 2'd2;

    localparam logic [7:0]  LABEL_BITS   = 8'd24;
    localparam logic [7:0]  MAX_BITS_V4  = 8'd32;
    localparam logic [7:0]  MAX_BITS_V6  = 8'd128;
    localparam logic [23:0] LABEL_WDRAW  = 24'h800000;
    localparam logic [4:0]  LABEL_BYTES  = 5'd3;

    typedef struct packed {
        logic afi_ipv6;
        logic labeled_mode;
        logic withdraw_mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0] phase;
        logic       err;
    } t_status;

    typedef struct packed {
        logic        route_valid;
        logic [63:0] prefix_high;
        logic [63:0] prefix_low;
        logic [7:0]  prefix_length;
        logic [19:0] route_label;
        logic        section_end;
        logic        malformed;
    } t_result;

endpackage

FILE: hw/rtl/nlpp_if.sv
// ----------------------------------------------------------------------------
// NLRI parser stream interfaces
// Valid/ready channels for section bytes in and parsed routes out.
// ----------------------------------------------------------------------------
interface nlpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nlpp_out_if;
    logic        valid;
    logic        ready;
    logic        route_valid;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [7:0]  prefix_length;
    logic [19:0] route_label;
    logic        section_end;
    logic        malformed;

    modport source (output valid, output route_valid, output prefix_high,
                    output prefix_low, output prefix_length, output route_label,
                    output section_end, output malformed, input ready);
    modport sink   (input valid, input route_valid, input prefix_high,
                    input prefix_low, input prefix_length, input route_label,
                    input section_end, input malformed, output ready);
endinterface

FILE: hw/rtl/nlri_prefix_label_parser_core.sv
// ----------------------------------------------------------------------------
// NLRI prefix/label parser core
// Output: a result is registered and is on the output in the cycle after the byte's transfer.
// Throughput: one byte per cycle; input stalls only while a held result is not taken.
// Reset: synchronous, active low; clears parse state, error, config, output valid.
// ----------------------------------------------------------------------------
`include "nlri_prefix_label_parser_core_assert.svh"

module nlri_prefix_label_parser_core
    import nlpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    nlpp_in_if.sink               i_in,
    nlpp_out_if.source            o_out
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;
    logic    w_accept;
    logic    w_emit;
    t_result w_result;
    t_status w_status;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AFI_IPV6:      r_cfg.afi_ipv6      <= i_cfg_wdata[0];
                CFG_LABELED_MODE:  r_cfg.labeled_mode  <= i_cfg_wdata[0];
                CFG_WITHDRAW_MODE: r_cfg.withdraw_mode <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    nlpp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .i_cfg       (r_cfg),
        .o_emit      (w_emit),
        .o_result    (w_result),
        .o_status    (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.route_valid   = r_out.route_valid;
    assign o_out.prefix_high   = r_out.prefix_high;
    assign o_out.prefix_low    = r_out.prefix_low;
    assign o_out.prefix_length = r_out.prefix_length;
    assign o_out.route_label   = r_out.route_label;
    assign o_out.section_end   = r_out.section_end;
    assign o_out.malformed     = r_out.malformed;

    // assertions
    `NLPP_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, i_in.ready,
                     "input stalled with empty output")
    `NLPP_ASSERT_NXT(a_last_gives_end, i_clk, i_rst_n,
                     i_rst_n && w_accept && i_in.last_byte,
                     o_out.valid && o_out.section_end,
                     "last byte gave no section end")
    `NLPP_ASSERT_NXT(a_last_clears, i_clk, i_rst_n,
                     i_rst_n && w_accept && i_in.last_byte,
                     w_status.phase == PH_LENGTH && !w_status.err,
                     "parse state not cleared after last byte")

endmodule

FILE: hw/rtl/nlpp_parser.sv
// ----------------------------------------------------------------------------
// NLRI parser state machine
// Per-byte parse state update and route result formation.
// ----------------------------------------------------------------------------
module nlpp_parser
    import nlpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  t_cfg       i_cfg,
    output logic       o_emit,
    output t_result    o_result,
    output t_status    o_status
);

    logic [1:0]   r_phase,  n_phase;
    logic [7:0]   r_bits,   n_bits;
    logic [4:0]   r_cnt,    n_cnt;
    logic [23:0]  r_acc,    n_acc;
    logic         r_first,  n_first;
    logic [19:0]  r_kept,   n_kept;
    logic [127:0] r_prefix, n_prefix;
    logic         r_err,    n_err;

    logic         route;
    logic         bp_req;
    logic [7:0]   bp_bits;
    logic [7:0]   fam_max;
    logic [23:0]  acc_new;
    logic [5:0]   cnt_inc;
    logic [5:0]   nbytes;
    logic [8:0]   bits_round;
    logic [127:0] mask;
    logic [127:0] masked;

    assign fam_max    = i_cfg.afi_ipv6 ? MAX_BITS_V6 : MAX_BITS_V4;
    assign acc_new    = {r_acc[15:0], i_data_byte};
    assign cnt_inc    = {1'b0, r_cnt} + 6'd1;
    assign bits_round = {1'b0, r_bits} + 9'd7;
    assign nbytes     = bits_round[8:3];

    always_comb begin
        n_phase  = r_phase;
        n_bits   = r_bits;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_first  = r_first;
        n_kept   = r_kept;
        n_prefix = r_prefix;
        n_err    = r_err;
        route    = 1'b0;
        bp_req   = 1'b0;
        bp_bits  = r_bits;
        o_result = '0;

        if (!r_err) begin
            case (r_phase)
                PH_LENGTH: begin
                    n_bits   = i_data_byte;
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_first  = 1'b0;
                    n_kept   = '0;
                    n_prefix = '0;
                    if (i_cfg.labeled_mode) begin
                        if (i_data_byte < LABEL_BITS) begin
                            n_err = 1'b1;
                        end else begin
                            n_phase = PH_LABEL;
                        end
                    end else begin
                        bp_req  = 1'b1;
                        bp_bits = i_data_byte;
                    end
                end
                PH_LABEL: begin
                    if (cnt_inc >= {1'b0, LABEL_BYTES}) begin
                        n_cnt   = '0;
                        n_acc   = '0;
                        bp_bits = r_bits - LABEL_BITS;
                        n_bits  = bp_bits;
                        if (!r_first) begin
                            n_kept  = acc_new[23:4];
                            n_first = 1'b1;
                        end
                        if (i_cfg.withdraw_mode || acc_new[0] || acc_new == LABEL_WDRAW) begin
                            bp_req = 1'b1;
                        end else if (bp_bits < LABEL_BITS) begin
                            n_err = 1'b1;
                        end
                    end else begin
                        n_acc = acc_new;
                        n_cnt = cnt_inc[4:0];
                    end
                end
                PH_PREFIX: begin
                    n_prefix = r_prefix | (128'(i_data_byte) << {~r_cnt[3:0], 3'b000});
                    if (cnt_inc >= nbytes) begin
                        n_cnt   = '0;
                        n_phase = PH_LENGTH;
                        route   = 1'b1;
                    end else begin
                        n_cnt = cnt_inc[4:0];
                    end
                end
                default: begin
                    n_phase = PH_LENGTH;
                end
            endcase
        end

        // labels done or unlabeled length byte: check the prefix length
        if (bp_req) begin
            if (bp_bits > fam_max) begin
                n_err = 1'b1;
            end else begin
                n_cnt = '0;
                if (bp_bits == 8'd0) begin
                    n_phase = PH_LENGTH;
                    route   = 1'b1;
                end else begin
                    n_phase = PH_PREFIX;
                end
            end
        end

        mask   = ~({128{1'b1}} >> n_bits);
        masked = n_prefix & mask;

        if (route) begin
            o_result.route_valid   = 1'b1;
            o_result.prefix_high   = masked[127:64];
            o_result.prefix_low    = masked[63:0];
            o_result.prefix_length = n_bits;
            o_result.route_label   = n_kept;
        end

        if (i_last_byte) begin
            o_result.section_end = 1'b1;
            o_result.malformed   = n_err || (n_phase != PH_LENGTH);
            n_phase  = PH_LENGTH;
            n_bits   = '0;
            n_cnt    = '0;
            n_acc    = '0;
            n_first  = 1'b0;
            n_kept   = '0;
            n_prefix = '0;
            n_err    = 1'b0;
        end
    end

    assign o_emit   = route || i_last_byte;
    assign o_status = '{phase: r_phase, err: r_err};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LENGTH;
            r_bits   <= '0;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_first  <= 1'b0;
            r_kept   <= '0;
            r_prefix <= '0;
            r_err    <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_bits   <= n_bits;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_first  <= n_first;
            r_kept   <= n_kept;
            r_prefix <= n_prefix;
            r_err    <= n_err;
        end
    end

endmodule
